>>> src/bcr_pkg.sv
// Shared constants, request codes and controller/datapath link types
// for the banked language card RAM. No dependencies.
package bcr_pkg;

   localparam int BANK_LG         = 14;
   localparam int BANK_BYTES      = 1 << BANK_LG;
   localparam int MAX_RAM_BYTES_D = 131072;
   localparam int IDX_W           = 17;    // index width at the largest card
   localparam int SIZE_W          = 5;
   localparam int SIZE_LG_MIN     = 14;
   localparam int SIZE_LG_MAX     = 17;
   localparam int SIZE_LG_LARGE   = 16;    // 64K and up
   localparam logic [SIZE_W-1:0] SIZE_LG_RESET = SIZE_W'(17);

   localparam logic [1:0] REQ_SWITCH     = 2'd0;
   localparam logic [1:0] REQ_MEM_READ   = 2'd1;
   localparam logic [1:0] REQ_MEM_WRITE  = 2'd2;
   localparam logic [1:0] REQ_HARD_RESET = 2'd3;

   localparam logic [7:0]  STATUS_BASE = 8'hC0;
   localparam logic [15:0] WIN_LOW     = 16'hD000;
   localparam logic [15:0] WIN_UPPER   = 16'hE000;

   typedef struct packed {
      logic take;    // transaction accepted this cycle
      logic sweep;   // clear one RAM entry this cycle
   } cmd_type;

   typedef struct packed {
      logic out_full;
      logic sweep_last;
      logic hard_rst;
   } sts_type;

endpackage

>>> src/bcr_req_if.sv
// Request channel: valid/ready plus one bus access.
// Depends on nothing.
interface bcr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] addr;
   logic [7:0]  write_data;

   modport source (output valid, req_type, addr, write_data, input ready);
   modport sink (input valid, req_type, addr, write_data, output ready);
endinterface

>>> src/bcr_rsp_if.sv
// Response channel: valid/ready plus read data and switch state.
// Depends on nothing.
interface bcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       data_valid;
   logic       ram_read_on;
   logic       ram_write_on;
   logic [2:0] bank_now;

   modport source (output valid, read_data, data_valid, ram_read_on, ram_write_on,
                   bank_now, input ready);
   modport sink (input valid, read_data, data_valid, ram_read_on, ram_write_on,
                 bank_now, output ready);
endinterface

>>> src/bcr_ctrl.sv
// Controller: RAM clearing pass versus normal operation, and the
// request handshake. Uses bcr_pkg.
module bcr_ctrl
   import bcr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic S_CLEAR = 1'b0;
   localparam logic S_RUN   = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      req_ready = (state_ff == S_RUN) && (!sts.out_full || rsp_ready);
      cmd.take  = req_valid && req_ready;
      cmd.sweep = (state_ff == S_CLEAR);
      state_in  = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.sweep_last) state_in = S_RUN;
         end
         S_RUN: begin
            if (cmd.take && sts.hard_rst) state_in = S_CLEAR;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_hard_rst_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.take && sts.hard_rst |=> state_ff == S_CLEAR)
      else $error("hard reset did not start clearing pass");

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take && cmd.sweep))
      else $error("transaction taken during clearing pass");

endmodule

>>> src/bcr_dp.sv
// Datapath: size register, soft switches, address mapping, card RAM,
// clearing counter and response register. Uses bcr_pkg.
module bcr_dp
   import bcr_pkg::*;
#(
   parameter int MAX_RAM_BYTES = MAX_RAM_BYTES_D
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   input  logic [1:0]        req_type,
   input  logic [15:0]       addr,
   input  logic [7:0]        write_data,
   input  logic              rsp_ready,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   output logic [7:0]        read_data,
   output logic              data_valid,
   output logic              ram_read_on,
   output logic              ram_write_on,
   output logic [2:0]        bank_now
);

   localparam int AW     = $clog2(MAX_RAM_BYTES);
   localparam int MAX_LG = $clog2(MAX_RAM_BYTES + 1) - 1;

   logic [7:0] mem [MAX_RAM_BYTES];

   logic [SIZE_W-1:0] size_ff;
   logic read_on_ff, read_on_in, write_on_ff, write_on_in;
   logic odd_ff, odd_in, page_ff, page_in;
   logic [2:0] bank_ff, bank_in;
   logic [AW-1:0] cnt_ff;
   logic out_full_ff;
   logic from_ram_ff;
   logic [7:0] misc_q_ff, ram_q_ff;
   logic dvalid_ff;

   logic [SIZE_W-1:0] lg_eff;
   logic [IDX_W-1:0]  sz_mask, base, idx;
   logic [BANK_LG-1:0] off;
   logic [2:0] bank_mask;
   logic narrow_card, in_win;
   logic [7:0] status;
   logic is_switch, is_read, is_write, is_hard;
   logic mem_we, rd_hit;
   logic [AW-1:0] mem_addr;
   logic [7:0] mem_wdata;

   always_comb begin
      // clamp the size code, then limit to what is installed
      if (size_ff < SIZE_W'(SIZE_LG_MIN))      lg_eff = SIZE_W'(SIZE_LG_MIN);
      else if (size_ff > SIZE_W'(SIZE_LG_MAX)) lg_eff = SIZE_W'(SIZE_LG_MAX);
      else                                     lg_eff = size_ff;
      if (lg_eff > SIZE_W'(MAX_LG)) lg_eff = SIZE_W'(MAX_LG);
      sz_mask     = IDX_W'(((IDX_W+1)'(1) << lg_eff) - (IDX_W+1)'(1));
      bank_mask   = 3'(sz_mask >> BANK_LG);
      narrow_card = lg_eff < SIZE_W'(SIZE_LG_LARGE);

      status = STATUS_BASE | {4'b0, page_ff, 1'b0, (read_on_ff == write_on_ff), write_on_ff};

      in_win = addr >= WIN_LOW;
      if (addr < WIN_UPPER) off = {1'b0, page_ff, addr[11:0]};
      else                  off = {1'b1, addr[12:0]};
      base = {bank_ff, {BANK_LG{1'b0}}} & sz_mask;
      idx  = (base | IDX_W'(off)) & sz_mask;

      is_switch = req_type == REQ_SWITCH;
      is_read   = req_type == REQ_MEM_READ;
      is_write  = req_type == REQ_MEM_WRITE;
      is_hard   = req_type == REQ_HARD_RESET;

      rd_hit = is_read && read_on_ff && in_win;
      mem_we = cmd.sweep || (cmd.take && is_write && write_on_ff && in_win);
      mem_addr  = cmd.sweep ? cnt_ff : idx[AW-1:0];
      mem_wdata = cmd.sweep ? 8'd0 : write_data;

      read_on_in  = read_on_ff;
      write_on_in = write_on_ff;
      odd_in      = odd_ff;
      page_in     = page_ff;
      bank_in     = bank_ff;
      if (cmd.take && is_hard) begin
         read_on_in  = 1'b0;
         write_on_in = 1'b0;
         odd_in      = 1'b0;
         page_in     = 1'b0;
         bank_in     = 3'd0;
      end else if (cmd.take && is_switch) begin
         if (addr[2] && !narrow_card) begin
            bank_in = {addr[3], addr[1:0]} & bank_mask;
         end else begin
            if (narrow_card) bank_in = {2'b0, addr[2]} & bank_mask;
            unique case (addr[1:0])
               2'd0: begin read_on_in = 1'b1; write_on_in = 1'b0;   end
               2'd1: begin read_on_in = 1'b0; write_on_in = odd_ff; end
               2'd2: begin read_on_in = 1'b0; write_on_in = 1'b0;   end
               default: begin read_on_in = 1'b1; write_on_in = odd_ff; end
            endcase
            odd_in  = addr[0];
            page_in = addr[3];
         end
      end

      sts.out_full   = out_full_ff;
      sts.sweep_last = cnt_ff == AW'(MAX_RAM_BYTES - 1);
      sts.hard_rst   = is_hard;

      rsp_valid    = out_full_ff;
      read_data    = from_ram_ff ? ram_q_ff : misc_q_ff;
      data_valid   = dvalid_ff;
      ram_read_on  = read_on_ff;
      ram_write_on = write_on_ff;
      bank_now     = bank_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.take) ram_q_ff <= mem[idx[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         from_ram_ff <= rd_hit;
         misc_q_ff   <= is_switch ? status : 8'd0;
         dvalid_ff   <= is_switch || rd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_LG_RESET;
         read_on_ff  <= 1'b0;
         write_on_ff <= 1'b0;
         odd_ff      <= 1'b0;
         page_ff     <= 1'b0;
         bank_ff     <= 3'd0;
         cnt_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (csr_we) size_ff <= csr_wdata;
         read_on_ff  <= read_on_in;
         write_on_ff <= write_on_in;
         odd_ff      <= odd_in;
         page_ff     <= page_in;
         bank_ff     <= bank_in;
         if (cmd.sweep) cnt_ff <= sts.sweep_last ? '0 : cnt_ff + AW'(1);
         if (cmd.take)       out_full_ff <= 1'b1;
         else if (rsp_ready) out_full_ff <= 1'b0;
      end
   end

   a_hard_rst_switches: assert property (@(posedge clock) disable iff (reset)
      cmd.take && is_hard |=> !read_on_ff && !write_on_ff && bank_ff == 3'd0 && !page_ff)
      else $error("hard reset left switches set");

   a_write_no_data: assert property (@(posedge clock) disable iff (reset)
      cmd.take && (is_write || is_hard) |=> !dvalid_ff && !from_ram_ff)
      else $error("write or hard reset returned data");

   a_write_needs_odd: assert property (@(posedge clock) disable iff (reset)
      !write_on_ff && write_on_in |-> odd_ff && cmd.take && is_switch)
      else $error("write enable rose without a repeated odd switch");

endmodule

>>> src/banked_language_card_ram_top.sv
// Top level of the banked language card RAM: controller plus datapath.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if, bcr_ctrl and bcr_dp.
//
// Usage:
//  - req_chan carries one bus access per transaction: soft switch access,
//    memory read, memory write or hard reset. rsp_chan returns exactly one
//    response per request: read data (old status byte or RAM byte), its
//    valid flag, and the switch state after the access.
//  - csr_we/csr_wdata load the RAM size code (log2 bytes); write it only
//    while no request is outstanding.
//  - The response is registered at the edge that accepts the request.
//    Throughput is one transaction per cycle while the receiver keeps up,
//    set by the single-port RAM read or write done at acceptance.
//  - After reset, and after a hard reset transaction, a clearing pass
//    zeroes the RAM one byte per cycle, all MAX_RAM_BYTES bytes (131072 by
//    default), during which req_chan.ready stays low.
//  - When the receiver stalls, the response register holds and a new
//    request is taken only in the cycle the held response is taken.
module banked_language_card_ram_top
   import bcr_pkg::*;
#(
   parameter int MAX_RAM_BYTES = MAX_RAM_BYTES_D
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   bcr_req_if.sink           req_chan,
   bcr_rsp_if.source         rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   bcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcr_dp #(
      .MAX_RAM_BYTES (MAX_RAM_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_type     (req_chan.req_type),
      .addr         (req_chan.addr),
      .write_data   (req_chan.write_data),
      .rsp_ready    (rsp_chan.ready),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_chan.valid),
      .read_data    (rsp_chan.read_data),
      .data_valid   (rsp_chan.data_valid),
      .ram_read_on  (rsp_chan.ram_read_on),
      .ram_write_on (rsp_chan.ram_write_on),
      .bank_now     (rsp_chan.bank_now)
   );

endmodule

>>> bench/tb_banked_language_card_ram_top.sv
// Testbench for banked_language_card_ram_top: directed and random bus accesses
// checked against a cycle-free model of the card held in a scoreboard class.
// Depends on bcr_pkg, bcr_req_if, bcr_rsp_if and the RTL under src.
module tb_banked_language_card_ram_top;
   import bcr_pkg::*;

   localparam int QUIET_LIMIT     = 600000;  // several clearing passes
   localparam int ITEMS_PER_PHASE = 130;
   localparam bit [SIZE_W-1:0] PHASE_SIZE [8] = '{5'd16, 5'd14, 5'd15, 5'd31,
                                                  5'd0, 5'd17, 5'd20, 5'd16};

   typedef struct packed {
      logic [7:0] read_data;
      logic       data_valid;
      logic       ram_read_on;
      logic       ram_write_on;
      logic [2:0] bank_now;
   } card_rsp_type;

   class card_shadow;
      bit [7:0]        ram_img [MAX_RAM_BYTES_D];
      bit              rd_en, wr_en, odd_prev, hi_page;
      bit [2:0]        bank;
      bit [SIZE_W-1:0] size_code;
      card_rsp_type    awaited [$];
      int              fails;

      function new();
         size_code = SIZE_LG_RESET;
         fails = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (ram_img[i]) ram_img[i] = '0;
         rd_en = 0;
         wr_en = 0;
         odd_prev = 0;
         hi_page = 0;
         bank = '0;
      endfunction

      function int unsigned card_bytes();
         int unsigned lg;
         lg = size_code;
         if (lg < SIZE_LG_MIN) lg = SIZE_LG_MIN;
         if (lg > SIZE_LG_MAX) lg = SIZE_LG_MAX;
         return 1 << lg;
      endfunction

      function void pick_bank(bit [2:0] want);
         bank = want & 3'(card_bytes() / BANK_BYTES - 1);
      endfunction

      function bit map_addr(bit [15:0] a, output int unsigned idx);
         int unsigned sz, base, x;
         sz = card_bytes();
         base = (bank * BANK_BYTES) & (sz - 1);
         if (a < WIN_LOW) return 0;
         if (a < WIN_UPPER) x = base + (hi_page ? 32'h1000 : 32'h0) + a[11:0];
         else x = base + 32'h2000 + a[12:0];
         idx = x & (sz - 1);
         return 1;
      endfunction

      function void note_access(bit [1:0] kind, bit [15:0] a, bit [7:0] wd);
         card_rsp_type e;
         int unsigned  idx;
         bit           narrow, was_odd;
         e = '0;
         narrow = card_bytes() < 65536;
         case (kind)
            REQ_SWITCH: begin
               // status reflects the switches before this access
               e.read_data = STATUS_BASE | {4'b0, hi_page, 1'b0, rd_en == wr_en, wr_en};
               e.data_valid = 1'b1;
               if (a[2] && !narrow) begin
                  pick_bank({a[3], a[1:0]});
               end else begin
                  was_odd = odd_prev;
                  if (narrow) pick_bank({2'b00, a[2]});
                  rd_en = ~(a[1] ^ a[0]);
                  // write enable needs two odd switches in a row
                  wr_en = a[0] ? was_odd : 1'b0;
                  odd_prev = a[0];
                  hi_page = a[3];
               end
            end
            REQ_MEM_READ: begin
               if (rd_en && map_addr(a, idx)) begin
                  e.read_data = ram_img[idx];
                  e.data_valid = 1'b1;
               end
            end
            REQ_MEM_WRITE: begin
               if (wr_en && map_addr(a, idx)) ram_img[idx] = wd;
            end
            REQ_HARD_RESET: begin
               wipe();
            end
         endcase
         e.ram_read_on = rd_en;
         e.ram_write_on = wr_en;
         e.bank_now = bank;
         awaited.push_back(e);
      endfunction

      function void check_response(card_rsp_type got);
         card_rsp_type e;
         if (awaited.size() == 0) begin
            $error("response with no transaction outstanding");
            fails++;
            return;
         end
         e = awaited.pop_front();
         if (got.read_data !== e.read_data) begin
            $error("read_data: expected %0h, got %0h", e.read_data, got.read_data);
            fails++;
         end
         if (got.data_valid !== e.data_valid) begin
            $error("data_valid: expected %0b, got %0b", e.data_valid, got.data_valid);
            fails++;
         end
         if (got.ram_read_on !== e.ram_read_on) begin
            $error("ram_read_on: expected %0b, got %0b", e.ram_read_on, got.ram_read_on);
            fails++;
         end
         if (got.ram_write_on !== e.ram_write_on) begin
            $error("ram_write_on: expected %0b, got %0b", e.ram_write_on, got.ram_write_on);
            fails++;
         end
         if (got.bank_now !== e.bank_now) begin
            $error("bank_now: expected %0d, got %0d", e.bank_now, got.bank_now);
            fails++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   bcr_req_if req_if();
   bcr_rsp_if rsp_if();

   banked_language_card_ram_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   card_shadow shadow;
   int         sender_idle_pct;
   int         receiver_stall_pct;
   int         items_sent;
   int         hard_resets_left;
   int         quiet_cycles;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // monitor both channels; watchdog on cycles with no transaction
   always @(posedge clock) begin
      card_rsp_type got;
      bit           req_taken, rsp_taken;
      req_taken = !reset && req_if.valid === 1'b1 && req_if.ready === 1'b1;
      rsp_taken = !reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1;
      if (req_taken) shadow.note_access(req_if.req_type, req_if.addr, req_if.write_data);
      if (rsp_taken) begin
         got.read_data = rsp_if.read_data;
         got.data_valid = rsp_if.data_valid;
         got.ram_read_on = rsp_if.ram_read_on;
         got.ram_write_on = rsp_if.ram_write_on;
         got.bank_now = rsp_if.bank_now;
         shadow.check_response(got);
      end
      if (reset || req_taken || rsp_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(bit [1:0] kind, bit [15:0] a, bit [7:0] wd);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.addr <= a;
      req_if.write_data <= wd;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_size(bit [SIZE_W-1:0] code);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= code;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow.size_code = code;
   endtask

   // window addresses clustered at the page edges so reads hit earlier writes
   function automatic bit [15:0] window_addr();
      case ($urandom_range(4))
         0: return 16'hD000 + 16'($urandom_range(15));
         1: return 16'hDFF0 + 16'($urandom_range(15));
         2: return 16'hE000 + 16'($urandom_range(15));
         3: return 16'hFFF0 + 16'($urandom_range(15));
         default: return 16'($urandom_range(16'hFFFF, 16'hD000));
      endcase
   endfunction

   function automatic bit [15:0] switch_addr(bit [3:0] low);
      bit [11:0] upper;
      upper = ($urandom_range(3) == 0) ? 12'($urandom) : 12'hC08;
      return {upper, low};
   endfunction

   task automatic run_burst(int phase_end);
      int       r;
      bit [3:0] sel;
      r = $urandom_range(99);
      if (r < 2 && hard_resets_left > 0 && items_sent + 10 < phase_end) begin
         hard_resets_left--;
         send(REQ_HARD_RESET, 16'($urandom), 8'($urandom));
      end else if (r < 45) begin
         // unlock writes, store a few bytes, read them back
         sel = {1'($urandom), $urandom_range(3) == 0, 1'($urandom), 1'b1};
         send(REQ_SWITCH, switch_addr(sel), 8'($urandom));
         send(REQ_SWITCH, switch_addr(sel), 8'($urandom));
         repeat ($urandom_range(1, 4)) send(REQ_MEM_WRITE, window_addr(), 8'($urandom));
         if ($urandom_range(1)) send(REQ_SWITCH, switch_addr({sel[3], 3'b011}), 8'($urandom));
         repeat ($urandom_range(1, 4)) send(REQ_MEM_READ, window_addr(), 8'($urandom));
      end else if (r < 58) begin
         send(REQ_SWITCH, switch_addr(4'($urandom)), 8'($urandom));
      end else if (r < 90) begin
         send($urandom_range(1) ? REQ_MEM_READ : REQ_MEM_WRITE, window_addr(), 8'($urandom));
      end else begin
         send(2'($urandom_range(2)), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int phase_end;
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = SIZE_LG_RESET;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_MEM_READ;
      req_if.addr = '0;
      req_if.write_data = '0;
      rsp_if.ready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      items_sent = 0;
      hard_resets_left = 2;
      quiet_cycles = 0;
      shadow = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, write unlock, page and bank selects, hard reset
      send(REQ_MEM_READ, 16'hD000, 8'h00);
      send(REQ_SWITCH, 16'hC080, 8'h00);
      send(REQ_MEM_READ, 16'hFFFF, 8'h00);
      send(REQ_MEM_WRITE, 16'hD000, 8'h11);
      send(REQ_SWITCH, 16'hC081, 8'hFF);
      send(REQ_SWITCH, 16'hC081, 8'h00);
      send(REQ_MEM_WRITE, 16'hD000, 8'hFF);
      send(REQ_MEM_WRITE, 16'hFFFF, 8'h5A);
      send(REQ_MEM_WRITE, 16'hCFFF, 8'h77);
      send(REQ_SWITCH, 16'hC08B, 8'h00);
      send(REQ_MEM_WRITE, 16'hD000, 8'hA5);
      send(REQ_MEM_READ, 16'hD000, 8'h00);
      send(REQ_SWITCH, 16'hC083, 8'h00);
      send(REQ_MEM_READ, 16'hD000, 8'h00);
      send(REQ_MEM_READ, 16'hFFFF, 8'h00);
      send(REQ_MEM_READ, 16'hCFFF, 8'h00);
      send(REQ_SWITCH, 16'hC087, 8'h00);
      send(REQ_SWITCH, 16'hC08F, 8'h00);
      send(REQ_MEM_WRITE, 16'hE000, 8'h3C);
      send(REQ_MEM_READ, 16'hE000, 8'h00);
      send(REQ_SWITCH, 16'hC08C, 8'h00);
      send(REQ_MEM_READ, 16'hE000, 8'h00);
      send(REQ_SWITCH, 16'hC082, 8'h00);
      send(REQ_MEM_READ, 16'hE000, 8'h00);
      send(REQ_HARD_RESET, 16'h0000, 8'h00);
      send(REQ_SWITCH, 16'hFFFF, 8'hFF);

      for (int p = 0; p < 8; p++) begin
         write_size(PHASE_SIZE[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
         endcase
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) run_burst(phase_end);
      end

      settle();
      if (shadow.fails == 0 && shadow.awaited.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
